// ----- design/scsa_pkg.sv -----
// Package for the size class slab allocator: widths, codes and defaults.
// No dependencies.
package scsa_pkg;
  localparam int MaxSlots   = 128;
  localparam int NumClasses = 4;
  localparam int NumChunks  = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_CLASS = 2'd1;
  localparam logic [1:0] ST_NO_CHUNK = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] REG_SHIFT0 = 3'd0;
  localparam logic [2:0] REG_SHIFT1 = 3'd1;
  localparam logic [2:0] REG_SHIFT2 = 3'd2;
  localparam logic [2:0] REG_SHIFT3 = 3'd3;
  localparam logic [2:0] REG_SLOTS0 = 3'd4;
  localparam logic [2:0] REG_SLOTS1 = 3'd5;
  localparam logic [2:0] REG_SLOTS2 = 3'd6;
  localparam logic [2:0] REG_SLOTS3 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  class_index;
    logic [3:0]  chunk_index;
    logic [30:0] slot_offset;
    logic        chunk_released;
  } result_t;
endpackage

// ----- design/scsa_lowfree.sv -----
// Lowest clear bit finder over a slot bitmap, masked to a slot count.
// Depends on scsa_pkg for nothing but the house widths; purely combinational.
module scsa_lowfree #(
  parameter int MAX_SLOTS = scsa_pkg::MaxSlots
) (
  input  logic [MAX_SLOTS-1:0]         bitmap,
  input  logic [$clog2(MAX_SLOTS):0]   count,
  output logic                         found,
  output logic [$clog2(MAX_SLOTS)-1:0] index
);
  localparam int IW = $clog2(MAX_SLOTS);
  logic [MAX_SLOTS-1:0] freev;

  always_comb begin
    for (int i = 0; i < MAX_SLOTS; i++) begin
      freev[i] = !bitmap[i] && ((IW+1)'(i) < count);
    end
    found = |freev;
    index = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (freev[i]) begin
        index = IW'(i);
      end
    end
  end
endmodule

// ----- design/size_class_slab_allocator_unit.sv -----
// Top level of the size class slab allocator: sequencer, chunk table, config.
// Depends on scsa_pkg and scsa_lowfree.
//
//  channel | direction | handshake          | payload
//  in_     | slave     | in_tvalid/tready   | tdata: opcode,size,align,chunk,offset
//  out_    | master    | out_tvalid/tready  | tdata: status,class,chunk,offset,released
//  cfg_    | write     | cfg_we             | cfg_index, cfg_data
//
// An allocate visits the classes in order (at most NUM_CLASSES), then scans every
// chunk in S_SCAN and updates in S_ALLOC before its result is offered; a free
// is checked in S_FREE. One shared free-slot search serves every chunk
// visited. Reset is synchronous and clears every chunk's active bit; the block
// is not ready while an item is at work or its result waits.
module size_class_slab_allocator_unit #(
  parameter int MAX_SLOTS   = scsa_pkg::MaxSlots,
  parameter int NUM_CLASSES = scsa_pkg::NumClasses,
  parameter int NUM_CHUNKS  = scsa_pkg::NumChunks
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[0], req_size[25:1], req_alignment[50:26], free_chunk[54:51],
  // free_offset[85:55], zero fill to 88
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], class_index[3:2], chunk_index[7:4], slot_offset[38:8],
  // chunk_released[39]
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  localparam int IW = $clog2(MAX_SLOTS);
  localparam int KW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CLASS = 6'b000010,
    S_SCAN  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_FREE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r;

  logic [4:0] shift_r [4];
  logic [7:0] slots_r [4];

  logic [NUM_CHUNKS-1:0] active_r;
  logic [1:0]            cls_r   [NUM_CHUNKS];
  logic [MAX_SLOTS-1:0]  bmap_r  [NUM_CHUNKS];
  logic [7:0]            used_r  [NUM_CHUNKS];

  logic [24:0] size_r, align_r;
  logic [3:0]  fchunk_r;
  logic [30:0] foff_r;
  logic [CW-1:0] ci_r;
  logic [25:0] low_r;
  logic        matched_r;
  logic [1:0]  sel_r;
  logic [KW-1:0] k_r;
  logic        hit_r;
  logic [KW-1:0] hitk_r;
  logic [IW-1:0] hits_r;
  logic        freek_v_r;
  logic [KW-1:0] freek_r;
  scsa_pkg::result_t res_r;

  // effective slot count of the selected class, saturated to MAX_SLOTS
  logic [IW:0] eff;
  always_comb begin
    if (slots_r[sel_r] > 8'(MAX_SLOTS)) eff = (IW+1)'(MAX_SLOTS);
    else eff = (IW+1)'(slots_r[sel_r]);
  end

  logic          lf_found;
  logic [IW-1:0] lf_idx;
  scsa_lowfree #(.MAX_SLOTS(MAX_SLOTS)) u_lowfree (
    .bitmap(bmap_r[k_r]), .count(eff), .found(lf_found), .index(lf_idx)
  );

  // A slot size beyond 2^25 covers every size and alignment, so it saturates.
  logic [25:0] ssz;
  assign ssz = (shift_r[2'(ci_r)] > 5'd25) ? 26'h3FFFFFF : (26'd1 << shift_r[2'(ci_r)]);

  logic [3:0]  kk;
  logic [1:0]  fcl;
  logic [30:0] fidx;
  logic        fok;
  assign kk   = fchunk_r;
  assign fcl  = cls_r[KW'(kk)];
  assign fidx = foff_r >> shift_r[fcl];
  always_comb begin
    logic [IW:0] fe;
    fe = (slots_r[fcl] > 8'(MAX_SLOTS)) ? (IW+1)'(MAX_SLOTS) : (IW+1)'(slots_r[fcl]);
    fok = (32'(kk) < NUM_CHUNKS) && active_r[KW'(kk)] && (fidx < 31'(fe))
          && bmap_r[KW'(kk)][IW'(fidx)];
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {res_r.chunk_released, res_r.slot_offset, res_r.chunk_index,
                       res_r.class_index, res_r.status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      active_r   <= '0;
      shift_r[0] <= 5'd4;  shift_r[1] <= 5'd6; shift_r[2] <= 5'd8; shift_r[3] <= 5'd10;
      slots_r[0] <= 8'd128; slots_r[1] <= 8'd64; slots_r[2] <= 8'd32; slots_r[3] <= 8'd16;
      for (int i = 0; i < NUM_CHUNKS; i++) begin
        bmap_r[i] <= '0;
        used_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          scsa_pkg::REG_SHIFT0: shift_r[0] <= cfg_data[4:0];
          scsa_pkg::REG_SHIFT1: shift_r[1] <= cfg_data[4:0];
          scsa_pkg::REG_SHIFT2: shift_r[2] <= cfg_data[4:0];
          scsa_pkg::REG_SHIFT3: shift_r[3] <= cfg_data[4:0];
          scsa_pkg::REG_SLOTS0: slots_r[0] <= cfg_data;
          scsa_pkg::REG_SLOTS1: slots_r[1] <= cfg_data;
          scsa_pkg::REG_SLOTS2: slots_r[2] <= cfg_data;
          scsa_pkg::REG_SLOTS3: slots_r[3] <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            size_r <= in_tdata[25:1]; align_r <= in_tdata[50:26];
            fchunk_r <= in_tdata[54:51]; foff_r <= in_tdata[85:55];
            ci_r <= '0; low_r <= '0; matched_r <= 1'b0;
            state_r <= in_tdata[0] ? S_FREE : S_CLASS;
          end
        end
        S_CLASS: begin
          // one class per cycle: range match, then alignment search upward
          if ((!matched_r && 26'(size_r) > low_r && 26'(size_r) <= ssz
               && 26'(align_r) <= ssz) || (matched_r && 26'(align_r) <= ssz)) begin
            sel_r <= 2'(ci_r); k_r <= '0; hit_r <= 1'b0; freek_v_r <= 1'b0;
            state_r <= S_SCAN;
          end else if (32'(ci_r) == NUM_CLASSES - 1) begin
            res_r <= '{status: scsa_pkg::ST_NO_CLASS, default: '0};
            state_r <= S_OUT;
          end else begin
            if (!matched_r && 26'(size_r) > low_r && 26'(size_r) <= ssz)
              matched_r <= 1'b1;
            low_r <= ssz;
            ci_r  <= ci_r + 1'b1;
          end
        end
        S_SCAN: begin
          if (!hit_r && active_r[k_r] && cls_r[k_r] == sel_r && lf_found) begin
            hit_r <= 1'b1; hitk_r <= k_r; hits_r <= lf_idx;
          end
          if (!freek_v_r && !active_r[k_r]) begin
            freek_v_r <= 1'b1; freek_r <= k_r;
          end
          if (32'(k_r) == NUM_CHUNKS - 1) state_r <= S_ALLOC;
          else k_r <= k_r + 1'b1;
        end
        S_ALLOC: begin
          state_r <= S_OUT;
          if (hit_r) begin
            bmap_r[hitk_r][hits_r] <= 1'b1;
            used_r[hitk_r] <= used_r[hitk_r] + 8'd1;
            res_r <= '{status: scsa_pkg::ST_OK, class_index: sel_r,
                       chunk_index: 4'(hitk_r),
                       slot_offset: 31'(hits_r) << shift_r[sel_r], chunk_released: 1'b0};
          end else if (freek_v_r && eff != '0) begin
            active_r[freek_r] <= 1'b1;
            cls_r[freek_r]    <= sel_r;
            bmap_r[freek_r]   <= MAX_SLOTS'(1);
            used_r[freek_r]   <= 8'd1;
            res_r <= '{status: scsa_pkg::ST_OK, class_index: sel_r,
                       chunk_index: 4'(freek_r), slot_offset: '0, chunk_released: 1'b0};
          end else begin
            res_r <= '{status: scsa_pkg::ST_NO_CHUNK, default: '0};
          end
        end
        S_FREE: begin
          state_r <= S_OUT;
          if (!fok) begin
            res_r <= '{status: scsa_pkg::ST_NO_CLASS, default: '0};
          end else begin
            res_r <= '{status: scsa_pkg::ST_OK, class_index: fcl, chunk_index: kk,
                       slot_offset: '0, chunk_released: (used_r[KW'(kk)] <= 8'd1)};
            if (used_r[KW'(kk)] <= 8'd1) begin
              active_r[KW'(kk)] <= 1'b0;
              bmap_r[KW'(kk)]   <= '0;
              used_r[KW'(kk)]   <= '0;
            end else begin
              bmap_r[KW'(kk)][IW'(fidx)] <= 1'b0;
              used_r[KW'(kk)] <= used_r[KW'(kk)] - 8'd1;
            end
          end
        end
        S_OUT: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // A result is offered only after the item has been worked on.
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_ALLOC || state_r == S_FREE
                                || state_r == S_CLASS))
    else $error("result raised without work");
  // A failed request reports zero in every other field.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_r.status != scsa_pkg::ST_OK |-> out_tdata[39:2] == '0)
    else $error("failed result carries data");
  // Input and output are never open in the same cycle.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("ready while result pending");
endmodule
